// ----- design/sfid_pkg.sv -----
`timescale 1ns / 1ps

package sfid_pkg;

	// Vertex index width; sums wrap at this width.
	localparam int IDX_W = 32;
	// Width of a decoded delta or a sum of up to three deltas (+-49152 fits).
	localparam int OFF_W = 17;
	// Queue between front and back.
	localparam int QPTR_W  = 1;
	localparam int Q_DEPTH = 2 ** QPTR_W;

	localparam logic [7:0] FACE_FULL    = 8'd1;
	localparam logic [7:0] FACE_SHARE_C = 8'd2;
	localparam logic [7:0] FACE_SHARE_A = 8'd3;
	localparam logic [7:0] FACE_SWAP    = 8'd4;

	localparam logic [OFF_W-1:0] DELTA_SHORT_BIAS = OFF_W'(64);
	localparam logic [OFF_W-1:0] DELTA_LONG_BIAS  = OFF_W'('hC000);
	localparam logic [7:0]       DELTA_LONG_MARK  = 8'd128;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_SHARE_C = 3'd2,
		KIND_SHARE_A = 3'd3,
		KIND_SWAP    = 3'd4
	} kind_t;

	typedef struct packed {
		logic       first_face;
		logic [7:0] face_kind;
		logic [7:0] window_byte_0;
		logic [7:0] window_byte_1;
		logic [7:0] window_byte_2;
		logic [7:0] window_byte_3;
		logic [7:0] window_byte_4;
		logic [7:0] window_byte_5;
	} face_t;

	typedef struct packed {
		logic signed [IDX_W-1:0] vert_a;
		logic signed [IDX_W-1:0] vert_b;
		logic signed [IDX_W-1:0] vert_c;
		logic [2:0]              bytes_used;
		logic                    kind_valid;
	} verts_t;

	// Classified request: offsets are relative to the previous C.
	typedef struct packed {
		logic             first_face;
		kind_t            kind;
		logic [OFF_W-1:0] off1;
		logic [OFF_W-1:0] off2;
		logic [OFF_W-1:0] off3;
		logic [2:0]       bytes_used;
	} dec_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	// One delta code starting at b0 (b1 used only for the two-byte form).
	function automatic logic [OFF_W-1:0] delta_val(input logic [7:0] b0, input logic [7:0] b1);
		logic [OFF_W-1:0] r;
		if (b0 >= DELTA_LONG_MARK) begin
			r = OFF_W'({b0, b1}) - DELTA_LONG_BIAS;
		end else begin
			r = OFF_W'(b0) - DELTA_SHORT_BIAS;
		end
		return r;
	endfunction

	function automatic logic [2:0] delta_len(input logic [7:0] b0);
		return (b0 >= DELTA_LONG_MARK) ? 3'd2 : 3'd1;
	endfunction

endpackage

// ----- design/sfid_front.sv -----
`timescale 1ns / 1ps

// Splits the byte window into deltas and classifies the face kind.
module sfid_front (
	input  sfid_pkg::face_t face,
	output sfid_pkg::dec_t  dec
);

	logic [7:0]                 win [6];
	logic [2:0]                 pos1;
	logic [2:0]                 pos2;
	logic [2:0]                 pos3;
	logic [sfid_pkg::OFF_W-1:0] d1;
	logic [sfid_pkg::OFF_W-1:0] d2;
	logic [sfid_pkg::OFF_W-1:0] d3;

	always_comb begin
		win[0] = face.window_byte_0;
		win[1] = face.window_byte_1;
		win[2] = face.window_byte_2;
		win[3] = face.window_byte_3;
		win[4] = face.window_byte_4;
		win[5] = face.window_byte_5;

		// chained delta starts; pos2 is at most 4 so pos2+1 stays in the window
		d1   = sfid_pkg::delta_val(win[0], win[1]);
		pos1 = sfid_pkg::delta_len(win[0]);
		d2   = sfid_pkg::delta_val(win[pos1], win[pos1 + 3'd1]);
		pos2 = pos1 + sfid_pkg::delta_len(win[pos1]);
		d3   = sfid_pkg::delta_val(win[pos2], win[pos2 + 3'd1]);
		pos3 = pos2 + sfid_pkg::delta_len(win[pos2]);
	end

	always_comb begin
		dec.first_face = face.first_face;
		dec.kind       = sfid_pkg::KIND_NONE;
		dec.off1       = d1;
		dec.off2       = d1 + d2;
		dec.off3       = d1 + d2 + d3;
		dec.bytes_used = 3'd0;
		case (face.face_kind)
			sfid_pkg::FACE_FULL: begin
				dec.kind       = sfid_pkg::KIND_FULL;
				dec.bytes_used = pos3;
			end
			sfid_pkg::FACE_SHARE_C: begin
				dec.kind       = sfid_pkg::KIND_SHARE_C;
				dec.bytes_used = pos1;
			end
			sfid_pkg::FACE_SHARE_A: begin
				dec.kind       = sfid_pkg::KIND_SHARE_A;
				dec.bytes_used = pos1;
			end
			sfid_pkg::FACE_SWAP: begin
				dec.kind       = sfid_pkg::KIND_SWAP;
				dec.bytes_used = pos1;
			end
			default: begin
				dec.kind       = sfid_pkg::KIND_NONE;
				dec.bytes_used = 3'd0;
			end
		endcase
	end

endmodule

// ----- design/sfid_queue.sv -----
`timescale 1ns / 1ps

// Small FIFO of classified requests between front and back.
module sfid_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfid_pkg::dec_t    wr_data,
	input  logic              pop,
	output sfid_pkg::dec_t    rd_data,
	output sfid_pkg::q_stat_t stat
);

	sfid_pkg::dec_t              mem_q [sfid_pkg::Q_DEPTH];
	logic [sfid_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sfid_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sfid_pkg::QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data        = mem_q[rd_ptr_q];
	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == (sfid_pkg::QPTR_W + 1)'(sfid_pkg::Q_DEPTH));

endmodule

// ----- design/sfid_back.sv -----
`timescale 1ns / 1ps

// Applies a classified request to the stored A/B/C and registers the result.
module sfid_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  sfid_pkg::dec_t   q_data,
	output logic             pop,
	output logic             verts_valid,
	input  logic             verts_stall,
	output sfid_pkg::verts_t verts
);

	logic [sfid_pkg::IDX_W-1:0] last_a_q;
	logic [sfid_pkg::IDX_W-1:0] last_b_q;
	logic [sfid_pkg::IDX_W-1:0] last_c_q;
	logic [sfid_pkg::IDX_W-1:0] base_a;
	logic [sfid_pkg::IDX_W-1:0] base_b;
	logic [sfid_pkg::IDX_W-1:0] base_c;
	logic [sfid_pkg::IDX_W-1:0] sum1;
	logic [sfid_pkg::IDX_W-1:0] sum2;
	logic [sfid_pkg::IDX_W-1:0] sum3;
	logic [sfid_pkg::IDX_W-1:0] nxt_a;
	logic [sfid_pkg::IDX_W-1:0] nxt_b;
	logic [sfid_pkg::IDX_W-1:0] nxt_c;
	logic                       known;
	logic                       out_valid_q;
	sfid_pkg::verts_t           out_q;

	localparam int EXT_W = sfid_pkg::IDX_W - sfid_pkg::OFF_W;

	assign pop = q_valid && (!out_valid_q || !verts_stall);

	always_comb begin
		base_a = q_data.first_face ? '0 : last_a_q;
		base_b = q_data.first_face ? '0 : last_b_q;
		base_c = q_data.first_face ? '0 : last_c_q;
		// three independent adds off the previous C
		sum1 = base_c + {{EXT_W{q_data.off1[sfid_pkg::OFF_W-1]}}, q_data.off1};
		sum2 = base_c + {{EXT_W{q_data.off2[sfid_pkg::OFF_W-1]}}, q_data.off2};
		sum3 = base_c + {{EXT_W{q_data.off3[sfid_pkg::OFF_W-1]}}, q_data.off3};
	end

	always_comb begin
		nxt_a = base_a;
		nxt_b = base_b;
		nxt_c = base_c;
		known = 1'b1;
		case (q_data.kind)
			sfid_pkg::KIND_FULL: begin
				nxt_a = sum1;
				nxt_b = sum2;
				nxt_c = sum3;
			end
			sfid_pkg::KIND_SHARE_C: begin
				nxt_b = base_c;
				nxt_c = sum1;
			end
			sfid_pkg::KIND_SHARE_A: begin
				nxt_a = base_c;
				nxt_c = sum1;
			end
			sfid_pkg::KIND_SWAP: begin
				nxt_a = base_b;
				nxt_b = base_a;
				nxt_c = sum1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q    <= '0;
			last_b_q    <= '0;
			last_c_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				last_a_q <= nxt_a;
				last_b_q <= nxt_b;
				last_c_q <= nxt_c;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!verts_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.vert_a     <= known ? nxt_a : '0;
			out_q.vert_b     <= known ? nxt_b : '0;
			out_q.vert_c     <= known ? nxt_c : '0;
			out_q.bytes_used <= known ? q_data.bytes_used : 3'd0;
			out_q.kind_valid <= known;
		end
	end

	assign verts_valid = out_valid_q;
	assign verts       = out_q;

endmodule

// ----- design/strip_face_index_decoder_core.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// face      in   face_valid / face_stall    sfid_pkg::face_t  (kind, first flag, 6 bytes)
// verts     out  verts_valid / verts_stall  sfid_pkg::verts_t (A, B, C, bytes used, ok)
//
// One face per clock sustained while verts_stall stays low. From face accept to the earliest
// verts accept, a face passes through the request queue, then the output register.
// The rate is set by the back end's 32-bit index adds, which feed the stored A/B/C
// of the next face; the front delta decode is stateless.
// Reset clears the stored indices to zero and empties queue and output register.
// face_stall rises only when the two-entry queue is full, so a stalled output
// lets two more faces in before the input stalls.
module strip_face_index_decoder_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             face_valid,
	output logic             face_stall,
	input  sfid_pkg::face_t  face,
	output logic             verts_valid,
	input  logic             verts_stall,
	output sfid_pkg::verts_t verts
);

	sfid_pkg::dec_t    dec;
	sfid_pkg::dec_t    q_data;
	sfid_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	// Front: delta lengths, offsets and kind, no state.
	sfid_front u_front (
		.face (face),
		.dec  (dec)
	);

	// Stall is registered-only: it comes from the queue fill, never from verts_stall.
	assign face_stall = q_stat.full;
	assign push       = face_valid && !face_stall;

	sfid_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (dec),
		.pop     (pop),
		.rd_data (q_data),
		.stat    (q_stat)
	);

	// Back: owns last A/B/C and the output register.
	sfid_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_stat.not_empty),
		.q_data      (q_data),
		.pop         (pop),
		.verts_valid (verts_valid),
		.verts_stall (verts_stall),
		.verts       (verts)
	);

	// An unknown kind reports nothing but zeros.
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verts_valid && !verts.kind_valid |->
			verts.bytes_used == 3'd0 && verts.vert_a == '0 &&
			verts.vert_b == '0 && verts.vert_c == '0)
		else $error("unknown face kind gave nonzero result");

	// A decoded face always consumes one to six bytes.
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		verts_valid && verts.kind_valid |->
			verts.bytes_used != 3'd0 && verts.bytes_used != 3'd7)
		else $error("bytes_used out of range");

	// Input stalls only while requests are queued.
	a_stall_needs_queue: assert property (@(posedge clk) disable iff (!arst_n)
		face_stall |-> q_stat.not_empty)
		else $error("input stalled with empty queue");

	// A request is drained into the output register whenever that register is free.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.not_empty && !(verts_valid && verts_stall) |=> verts_valid)
		else $error("queued request not moved to output");

endmodule

// ----- tb/strip_face_index_decoder_core_tb.sv -----
`timescale 1ns / 1ps

// Drives triangle-strip face requests into the index decoder and checks every
// returned triangle against an in-bench model of the strip rules: delta decode
// (one-byte and two-byte codes), the four face kinds, first-face clearing and
// the pass-through of unknown kinds. Runs a directed set first, then random
// strips under three idling mixes, with one full drain in between.
module strip_face_index_decoder_core_tb;

	// Delta stream coding
	localparam logic [31:0] SHORT_BIAS = 32'd64;
	localparam logic [31:0] LONG_BIAS  = 32'h0000_C000;
	localparam logic [7:0]  LONG_MARK  = 8'd128;

	// Cycles without any accepted request on either side before giving up.
	localparam int STALL_LIMIT  = 5000;
	// Quiet cycles after the last result.
	localparam int DRAIN_CYCLES = 10;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              face_valid  = 1'b0;
	logic              face_stall;
	sfid_pkg::face_t   face        = '0;
	logic              verts_valid;
	logic              verts_stall = 1'b0;
	sfid_pkg::verts_t  verts;

	strip_face_index_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.face_valid  (face_valid),
		.face_stall  (face_stall),
		.face        (face),
		.verts_valid (verts_valid),
		.verts_stall (verts_stall),
		.verts       (verts)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model copy of the stored triangle, updated in accept order.
	logic [31:0] idx_a = '0;
	logic [31:0] idx_b = '0;
	logic [31:0] idx_c = '0;

	sfid_pkg::verts_t pending_verts [$];
	sfid_pkg::verts_t want_verts;

	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int errors          = 0;
	int faces_sent      = 0;
	int unknown_sent    = 0;
	int strip_starts    = 0;
	int results_checked = 0;
	int quiet_cycles    = 0;

	// Next triangle for one accepted face; also advances the model state.
	function automatic sfid_pkg::verts_t predict_face(input sfid_pkg::face_t f);
		logic [7:0]       win [6];
		logic [31:0]      delta [3];
		logic [7:0]       lead;
		int unsigned      pos;
		int unsigned      n_deltas;
		sfid_pkg::verts_t v;
		win[0] = f.window_byte_0;
		win[1] = f.window_byte_1;
		win[2] = f.window_byte_2;
		win[3] = f.window_byte_3;
		win[4] = f.window_byte_4;
		win[5] = f.window_byte_5;
		pos = 0;
		v = '0;
		// clearing happens even for an unknown kind
		if (f.first_face) begin
			idx_a = '0;
			idx_b = '0;
			idx_c = '0;
		end
		case (f.face_kind)
			sfid_pkg::FACE_FULL: begin
				n_deltas = 3;
			end
			sfid_pkg::FACE_SHARE_C, sfid_pkg::FACE_SHARE_A, sfid_pkg::FACE_SWAP: begin
				n_deltas = 1;
			end
			default: begin
				n_deltas = 0;
			end
		endcase
		// unknown kind: all-zero result, nothing consumed, state kept
		if (n_deltas == 0)
			return v;
		for (int i = 0; i < n_deltas; i++) begin
			lead = win[pos % 6];
			if (lead >= LONG_MARK) begin
				delta[i] = {16'h0000, lead, win[(pos + 1) % 6]} - LONG_BIAS;
				pos += 2;
			end else begin
				delta[i] = {24'h000000, lead} - SHORT_BIAS;
				pos += 1;
			end
		end
		case (f.face_kind)
			sfid_pkg::FACE_FULL: begin
				v.vert_a = idx_c + delta[0];
				v.vert_b = v.vert_a + delta[1];
				v.vert_c = v.vert_b + delta[2];
			end
			sfid_pkg::FACE_SHARE_C: begin
				v.vert_a = idx_a;
				v.vert_b = idx_c;
				v.vert_c = idx_c + delta[0];
			end
			sfid_pkg::FACE_SHARE_A: begin
				v.vert_a = idx_c;
				v.vert_b = idx_b;
				v.vert_c = idx_c + delta[0];
			end
			default: begin
				// swap
				v.vert_a = idx_b;
				v.vert_b = idx_a;
				v.vert_c = idx_c + delta[0];
			end
		endcase
		idx_a = v.vert_a;
		idx_b = v.vert_b;
		idx_c = v.vert_c;
		v.bytes_used = 3'(pos);
		v.kind_valid = 1'b1;
		return v;
	endfunction

	function automatic sfid_pkg::face_t make_face(input logic first, input logic [7:0] kind,
			input logic [47:0] win);
		return sfid_pkg::face_t'({first, kind, win});
	endfunction

	// Stream byte biased toward the code boundaries.
	function automatic logic [7:0] stream_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'h3F;
			2: return 8'h40;
			3: return 8'h7F;
			4: return 8'h80;
			5: return 8'hBF;
			6: return 8'hC0;
			7: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One face request. Entered and left at a falling edge; valid stays up
	// between back-to-back requests so it is never dropped and raised in one step.
	task automatic send_face(input sfid_pkg::face_t f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			face_valid <= 1'b0;
			@(negedge clk);
		end
		face_valid <= 1'b1;
		face       <= f;
		do
			@(posedge clk);
		while (face_stall);
		pending_verts.push_back(predict_face(f));
		faces_sent++;
		if (f.face_kind < sfid_pkg::FACE_FULL || f.face_kind > sfid_pkg::FACE_SWAP)
			unknown_sent++;
		if (f.first_face)
			strip_starts++;
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding triangle.
	task automatic wait_drained();
		face_valid <= 1'b0;
		while (pending_verts.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Largest and smallest deltas of both code lengths, and byte counts 3..6.
	task automatic test_delta_extremes();
		send_face(make_face(1'b1, sfid_pkg::FACE_FULL, 48'h00_00_00_FF_FF_FF));
		send_face(make_face(1'b0, sfid_pkg::FACE_FULL, 48'h7F_7F_7F_00_00_00));
		send_face(make_face(1'b0, sfid_pkg::FACE_FULL, 48'h80_00_80_00_80_00));
		send_face(make_face(1'b0, sfid_pkg::FACE_FULL, 48'hFF_FF_FF_FF_FF_FF));
		send_face(make_face(1'b0, sfid_pkg::FACE_FULL, 48'hC0_00_40_BF_FF_7F));
		send_face(make_face(1'b0, sfid_pkg::FACE_FULL, 48'h40_C0_00_40_12_34));
	endtask

	// Each shared-edge kind with short and long codes, and with the clear flag.
	task automatic test_face_kinds();
		send_face(make_face(1'b0, sfid_pkg::FACE_SHARE_C, 48'h41_FF_FF_FF_FF_FF));
		send_face(make_face(1'b0, sfid_pkg::FACE_SHARE_A, 48'h80_01_00_00_00_00));
		send_face(make_face(1'b0, sfid_pkg::FACE_SWAP,    48'hFF_FF_AA_55_AA_55));
		send_face(make_face(1'b0, sfid_pkg::FACE_SWAP,    48'h3F_80_80_80_80_80));
		send_face(make_face(1'b1, sfid_pkg::FACE_SHARE_C, 48'hBF_FF_00_00_00_00));
		send_face(make_face(1'b1, sfid_pkg::FACE_SHARE_A, 48'h7F_00_00_00_00_00));
		send_face(make_face(1'b1, sfid_pkg::FACE_SWAP,    48'h00_FF_FF_FF_FF_FF));
	endtask

	// Unknown kinds leave the triangle alone, except the clear flag still acts.
	task automatic test_unknown_kinds();
		send_face(make_face(1'b0, sfid_pkg::FACE_FULL,    48'h55_66_77_00_00_00));
		send_face(make_face(1'b0, 8'd0,                   48'hFF_FF_FF_FF_FF_FF));
		send_face(make_face(1'b0, 8'd5,                   48'h80_00_80_00_80_00));
		send_face(make_face(1'b0, 8'd128,                 48'h00_00_00_00_00_00));
		send_face(make_face(1'b0, 8'd255,                 48'hAA_55_AA_55_AA_55));
		send_face(make_face(1'b0, sfid_pkg::FACE_SWAP,    48'h41_00_00_00_00_00));
		send_face(make_face(1'b1, 8'd255,                 48'h41_41_41_41_41_41));
		send_face(make_face(1'b0, sfid_pkg::FACE_SHARE_C, 48'h7F_00_00_00_00_00));
	endtask

	// Strips opened by a full face with the clear flag, then mostly shared-edge
	// faces; a few unknown kinds and mid-strip restarts as noise. n_faces counts
	// decoded faces only.
	task automatic test_random_strips(input int n_faces);
		int          left;
		int          strip_len;
		int          roll;
		logic        first;
		logic [7:0]  kind;
		logic [47:0] win;
		left = n_faces;
		while (left > 0) begin
			strip_len = $urandom_range(1, 40);
			for (int k = 0; k < strip_len && left > 0; k++) begin
				roll  = $urandom_range(0, 99);
				first = 1'b0;
				if (k == 0) begin
					first = 1'b1;
					kind  = sfid_pkg::FACE_FULL;
				end else if (roll < 28) begin
					kind = sfid_pkg::FACE_SHARE_C;
				end else if (roll < 56) begin
					kind = sfid_pkg::FACE_SHARE_A;
				end else if (roll < 84) begin
					kind = sfid_pkg::FACE_SWAP;
				end else if (roll < 90) begin
					kind = sfid_pkg::FACE_FULL;
				end else if (roll < 96) begin
					kind  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(5, 255));
					first = 1'($urandom_range(0, 1));
				end else begin
					first = 1'b1;
					kind  = 8'($urandom_range(sfid_pkg::FACE_FULL, sfid_pkg::FACE_SWAP));
				end
				for (int j = 0; j < 6; j++)
					win = {win[39:0], stream_byte()};
				send_face(make_face(first, kind, win));
				if (kind >= sfid_pkg::FACE_FULL && kind <= sfid_pkg::FACE_SWAP)
					left--;
			end
		end
	endtask

	// Sender holds off until the pipe is empty, then picks up again.
	task automatic test_pause_until_drained();
		test_random_strips(12);
		wait_drained();
		test_random_strips(12);
	endtask

	// Receiver stall, updated on the falling edge like every other input.
	always @(negedge clk)
		verts_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// Result checker: oldest prediction against each accepted triangle.
	always @(posedge clk) begin
		if (arst_n && verts_valid && !verts_stall) begin
			if (pending_verts.size() == 0) begin
				$error("triangle returned with no face pending");
				errors++;
			end else begin
				want_verts = pending_verts.pop_front();
				results_checked++;
				if (verts.vert_a !== want_verts.vert_a) begin
					$error("vert_a: expected %0d, got %0d", want_verts.vert_a, verts.vert_a);
					errors++;
				end
				if (verts.vert_b !== want_verts.vert_b) begin
					$error("vert_b: expected %0d, got %0d", want_verts.vert_b, verts.vert_b);
					errors++;
				end
				if (verts.vert_c !== want_verts.vert_c) begin
					$error("vert_c: expected %0d, got %0d", want_verts.vert_c, verts.vert_c);
					errors++;
				end
				if (verts.bytes_used !== want_verts.bytes_used) begin
					$error("bytes_used: expected %0d, got %0d",
						want_verts.bytes_used, verts.bytes_used);
					errors++;
				end
				if (verts.kind_valid !== want_verts.kind_valid) begin
					$error("kind_valid: expected %0d, got %0d",
						want_verts.kind_valid, verts.kind_valid);
					errors++;
				end
			end
		end
	end

	// Watchdog: any accepted request on either side restarts the count.
	always @(posedge clk) begin
		if ((face_valid && !face_stall) || (verts_valid && !verts_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_delta_extremes();
		test_face_kinds();
		test_unknown_kinds();

		// sender idles a little, receiver a lot
		send_idle_pct = 28;
		recv_idle_pct = 59;
		test_random_strips(330);
		test_pause_until_drained();

		// the other way round
		send_idle_pct = 59;
		recv_idle_pct = 28;
		test_random_strips(340);

		// full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_strips(340);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d faces in %0d strip starts, %0d of unknown kind; %0d triangles checked",
			faces_sent, strip_starts, unknown_sent, results_checked);
		$display("under sender-heavy, receiver-heavy and stall-free traffic, with one full drain.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/sfid_pkg.sv
design/sfid_front.sv
design/sfid_queue.sv
design/sfid_back.sv
design/strip_face_index_decoder_core.sv
tb/strip_face_index_decoder_core_tb.sv
